@@ rtl/rle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_pkg
// shared constants, types and sequencer codes of the run-length compressor
// ----------------------------------------------------------------------------
package rle_pkg;

    // longest literal run before it is split, longest repeat run
    localparam int RAW_MAX    = 32;
    localparam int REPEAT_MAX = 32767;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 24;                         // body length, size and padded length
    localparam int REP_W  = 15;                         // repeat counter
    localparam int CNT_W  = 16;                         // count word on the wire
    localparam int LC_W   = $clog2(RAW_MAX + 1);        // literal counter, holds RAW_MAX itself
    localparam int ADDR_W = (RAW_MAX > 1) ? $clog2(RAW_MAX) : 1;

    localparam logic [CNT_W-1:0] CNT_MASK = 16'h7FFF;
    localparam logic [CNT_W-1:0] REP_FLAG = 16'h8000;
    // header words plus rounding slack, then clear the low two bits
    localparam int               HDR_BYTES = 8;
    localparam logic [LEN_W-1:0] SIZE_ADD  = 24'd4;
    localparam logic [LEN_W-1:0] PAD_ADD   = LEN_W'(HDR_BYTES + 3);
    localparam logic [LEN_W-1:0] PAD_MASK  = 24'hFF_FFFC;
    localparam logic [LEN_W-1:0] REP_FLUSH_LEN = 24'd3;
    localparam logic [LEN_W-1:0] LIT_HDR_LEN   = 24'd2;
    localparam logic [REP_W-1:0] REP_START     = 15'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_TAIL,
        ST_LIT_ADD,
        ST_LEN,
        ST_LEN2,
        ST_SIZE,
        ST_PAD,
        ST_EMIT_LO,
        ST_EMIT_HI,
        ST_EMIT_DATA
    } t_state;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_LITERAL = 2'd1,
        MODE_REPEAT  = 2'd2
    } t_mode;

    typedef enum logic {
        KIND_LIT,
        KIND_REP
    } t_kind;

    typedef enum logic {
        ALU_ADD,
        ALU_EQ
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [LEN_W-1:0] a;
        logic [LEN_W-1:0] b;
    } t_alu_req;

endpackage

@@ rtl/rle_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_if
// valid/ready channels for raw input bytes and encoded output bytes
// ----------------------------------------------------------------------------
interface rle_in_if;
    logic                       valid;
    logic                       ready;
    logic [rle_pkg::BYTE_W-1:0] in_byte;
    logic                       block_end;

    modport source (output valid, output in_byte, output block_end, input ready);
    modport sink   (input valid, input in_byte, input block_end, output ready);
endinterface

interface rle_out_if;
    logic                       valid;
    logic                       ready;
    logic [rle_pkg::BYTE_W-1:0] out_byte;
    logic                       final_out;
    logic [rle_pkg::LEN_W-1:0]  size_word;
    logic [rle_pkg::LEN_W-1:0]  padded_length;

    modport source (output valid, output out_byte, output final_out, output size_word,
                    output padded_length, input ready);
    modport sink   (input valid, input out_byte, input final_out, input size_word,
                    input padded_length, output ready);
endinterface

@@ rtl/rle_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rle_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/rle_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_alu
// shared adder and equality compare, time-shared by the sequencer
// ----------------------------------------------------------------------------
module rle_alu (
    input  rle_pkg::t_alu_req           i_req,
    output logic [rle_pkg::LEN_W-1:0]   o_res
);

    always_comb begin
        unique case (i_req.op)
            rle_pkg::ALU_ADD: o_res = i_req.a + i_req.b;
            rle_pkg::ALU_EQ:  o_res = rle_pkg::LEN_W'(i_req.a == i_req.b);
            default:          o_res = '0;
        endcase
    end

endmodule

@@ rtl/rle_block_compressor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_block_compressor
// run-length compressor of one block: byte stream in, encoded body out
// ----------------------------------------------------------------------------
// usage
//   i_in carries one raw byte per transaction, block_end set on the final
//   byte. o_out carries one encoded body byte per transaction; final_out
//   marks the last byte of a block, and only then size_word (body + 4) and
//   padded_length ((body + 11) with the low two bits cleared) are nonzero.
//   magic and size header words are left to the surrounding logic.
// timing
//   one byte of lookahead is held, so the first byte of a block only
//   loads it. a byte that extends or starts a run goes through decide
//   and tail; a byte for the literal store through decide, store and
//   tail. the tail step takes the next transaction. a literal flush
//   adds length and header, then emits the count and stored bytes; a
//   repeat flush adds its length and emits the count and held bytes;
//   the final flush also adds size and padding. all of this is set by
//   the single shared adder/compare unit: one operation per cycle.
// reset and stall
//   synchronous active-low reset returns to idle with an empty lookahead.
//   results go through a one-deep output register; while the receiver
//   stalls, emission halts, but input is still taken in idle and tail.
// ----------------------------------------------------------------------------
module rle_block_compressor (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rle_in_if.sink         i_in,
    rle_out_if.source      o_out
);

    // sequencer and run state
    rle_pkg::t_state r_state, n_state;
    rle_pkg::t_mode  r_mode, n_mode;
    rle_pkg::t_kind  r_kind, n_kind;

    logic [rle_pkg::BYTE_W-1:0] r_x, n_x;
    logic                       r_end, n_end;
    logic [rle_pkg::BYTE_W-1:0] r_held, n_held;
    logic                       r_held_valid, n_held_valid;
    logic [rle_pkg::REP_W-1:0]  r_rc, n_rc;
    logic [rle_pkg::LC_W-1:0]   r_lc, n_lc;
    logic [rle_pkg::LEN_W-1:0]  r_body, n_body;
    logic [rle_pkg::LEN_W-1:0]  r_size, n_size;
    logic [rle_pkg::LEN_W-1:0]  r_pad, n_pad;
    logic [rle_pkg::ADDR_W-1:0] r_idx, n_idx;
    logic                       r_final, n_final;
    logic                       r_rc_inc, n_rc_inc;

    // output register
    logic                       r_out_valid, n_out_valid;
    logic [rle_pkg::BYTE_W-1:0] r_out_byte, n_out_byte;
    logic                       r_out_final, n_out_final;
    logic [rle_pkg::LEN_W-1:0]  r_out_size, n_out_size;
    logic [rle_pkg::LEN_W-1:0]  r_out_pad, n_out_pad;

    rle_pkg::t_alu_req          alu_req;
    logic [rle_pkg::LEN_W-1:0]  alu_res;

    logic                       in_ready;
    logic                       in_acc;
    logic                       can_emit;
    logic                       is_eq;
    logic                       rep_go;
    logic                       lit_full;
    logic                       data_last;
    logic [rle_pkg::CNT_W-1:0]  cnt_word;

    logic                       ram_we;
    logic [rle_pkg::BYTE_W-1:0] ram_rdata;

    rle_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    // literal store, read address runs one step ahead so the data is ready
    rle_ram #(
        .WIDTH (rle_pkg::BYTE_W),
        .DEPTH (rle_pkg::RAW_MAX)
    ) u_lit_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_lc[rle_pkg::ADDR_W-1:0]),
        .i_wdata (r_held),
        .i_raddr (n_idx),
        .o_rdata (ram_rdata)
    );

    assign in_ready = (r_state == rle_pkg::ST_IDLE) || (r_state == rle_pkg::ST_TAIL && !r_end);
    assign in_acc   = i_in.valid && in_ready;
    assign can_emit = !r_out_valid || o_out.ready;
    assign is_eq    = alu_res[0];
    assign rep_go   = (r_mode == rle_pkg::MODE_REPEAT) && is_eq
                      && (r_rc < rle_pkg::REP_W'(rle_pkg::REPEAT_MAX));
    assign lit_full = (alu_res == rle_pkg::LEN_W'(rle_pkg::RAW_MAX)) || r_final;
    // literal payload ends when the next index reaches the count
    assign data_last = (r_kind == rle_pkg::KIND_REP)
                       || (alu_res == rle_pkg::LEN_W'(r_lc));
    assign cnt_word = (r_kind == rle_pkg::KIND_REP)
                      ? ((rle_pkg::CNT_W'(r_rc) & rle_pkg::CNT_MASK) | rle_pkg::REP_FLAG)
                      : rle_pkg::CNT_W'(r_lc);

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte      = r_out_byte;
    assign o_out.final_out     = r_out_final;
    assign o_out.size_word     = r_out_size;
    assign o_out.padded_length = r_out_pad;

    // shared unit: one operation per state
    always_comb begin
        alu_req.op = rle_pkg::ALU_ADD;
        alu_req.a  = '0;
        alu_req.b  = '0;
        unique case (r_state)
            rle_pkg::ST_DECIDE: begin
                alu_req.op = rle_pkg::ALU_EQ;
                alu_req.a  = rle_pkg::LEN_W'(r_x);
                alu_req.b  = rle_pkg::LEN_W'(r_held);
            end
            rle_pkg::ST_TAIL: begin
                alu_req.a = rle_pkg::LEN_W'(r_rc);
                alu_req.b = rle_pkg::LEN_W'(1);
            end
            rle_pkg::ST_LIT_ADD: begin
                alu_req.a = rle_pkg::LEN_W'(r_lc);
                alu_req.b = rle_pkg::LEN_W'(1);
            end
            rle_pkg::ST_LEN: begin
                alu_req.a = r_body;
                alu_req.b = (r_kind == rle_pkg::KIND_REP) ? rle_pkg::REP_FLUSH_LEN
                                                          : rle_pkg::LEN_W'(r_lc);
            end
            rle_pkg::ST_LEN2: begin
                alu_req.a = r_body;
                alu_req.b = rle_pkg::LIT_HDR_LEN;
            end
            rle_pkg::ST_SIZE: begin
                alu_req.a = r_body;
                alu_req.b = rle_pkg::SIZE_ADD;
            end
            rle_pkg::ST_PAD: begin
                alu_req.a = r_body;
                alu_req.b = rle_pkg::PAD_ADD;
            end
            rle_pkg::ST_EMIT_DATA: begin
                alu_req.a = rle_pkg::LEN_W'(r_idx);
                alu_req.b = rle_pkg::LEN_W'(1);
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rle_pkg::ST_IDLE: begin
                if (in_acc) n_state = rle_pkg::ST_DECIDE;
            end
            rle_pkg::ST_DECIDE: begin
                priority if (!r_held_valid) begin
                    n_state = rle_pkg::ST_TAIL;
                end else if (r_mode == rle_pkg::MODE_REPEAT) begin
                    n_state = rep_go ? rle_pkg::ST_TAIL : rle_pkg::ST_LEN;
                end else if (is_eq) begin
                    n_state = (r_lc != '0) ? rle_pkg::ST_LEN : rle_pkg::ST_TAIL;
                end else begin
                    n_state = rle_pkg::ST_LIT_ADD;
                end
            end
            rle_pkg::ST_TAIL: begin
                priority if (r_end) begin
                    n_state = (r_mode == rle_pkg::MODE_REPEAT) ? rle_pkg::ST_LEN
                                                               : rle_pkg::ST_LIT_ADD;
                end else if (in_acc) begin
                    n_state = rle_pkg::ST_DECIDE;
                end else begin
                    n_state = rle_pkg::ST_IDLE;
                end
            end
            rle_pkg::ST_LIT_ADD: begin
                n_state = lit_full ? rle_pkg::ST_LEN : rle_pkg::ST_TAIL;
            end
            rle_pkg::ST_LEN: begin
                priority if (r_kind == rle_pkg::KIND_LIT) n_state = rle_pkg::ST_LEN2;
                else if (r_final)                          n_state = rle_pkg::ST_SIZE;
                else                                       n_state = rle_pkg::ST_EMIT_LO;
            end
            rle_pkg::ST_LEN2: begin
                n_state = r_final ? rle_pkg::ST_SIZE : rle_pkg::ST_EMIT_LO;
            end
            rle_pkg::ST_SIZE: n_state = rle_pkg::ST_PAD;
            rle_pkg::ST_PAD:  n_state = rle_pkg::ST_EMIT_LO;
            rle_pkg::ST_EMIT_LO: begin
                if (can_emit) n_state = rle_pkg::ST_EMIT_HI;
            end
            rle_pkg::ST_EMIT_HI: begin
                if (can_emit) n_state = rle_pkg::ST_EMIT_DATA;
            end
            rle_pkg::ST_EMIT_DATA: begin
                if (can_emit && data_last) begin
                    n_state = r_final ? rle_pkg::ST_IDLE : rle_pkg::ST_TAIL;
                end
            end
            default: n_state = rle_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_x          = r_x;
        n_end        = r_end;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_mode       = r_mode;
        n_kind       = r_kind;
        n_rc         = r_rc;
        n_lc         = r_lc;
        n_body       = r_body;
        n_size       = r_size;
        n_pad        = r_pad;
        n_idx        = r_idx;
        n_final      = r_final;
        n_rc_inc     = r_rc_inc;
        ram_we       = 1'b0;

        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_byte   = r_out_byte;
        n_out_final  = r_out_final;
        n_out_size   = r_out_size;
        n_out_pad    = r_out_pad;

        if (in_acc) begin
            n_x   = i_in.in_byte;
            n_end = i_in.block_end;
        end

        unique case (r_state)
            rle_pkg::ST_DECIDE: begin
                n_final  = 1'b0;
                n_rc_inc = 1'b0;
                if (r_held_valid) begin
                    priority if (r_mode == rle_pkg::MODE_REPEAT) begin
                        if (rep_go) begin
                            n_rc_inc = 1'b1;
                        end else begin
                            // run broken or at its limit: close it
                            n_kind = rle_pkg::KIND_REP;
                            n_mode = rle_pkg::MODE_IDLE;
                        end
                    end else if (is_eq) begin
                        // pending literals go out, a repeat run opens
                        n_kind = rle_pkg::KIND_LIT;
                        n_mode = rle_pkg::MODE_REPEAT;
                        n_rc   = rle_pkg::REP_START;
                    end else begin
                        n_mode = rle_pkg::MODE_LITERAL;
                    end
                end
            end
            rle_pkg::ST_TAIL: begin
                n_held       = r_x;
                n_held_valid = 1'b1;
                if (r_rc_inc) begin
                    n_rc     = alu_res[rle_pkg::REP_W-1:0];
                    n_rc_inc = 1'b0;
                end
                if (r_end) begin
                    n_final = 1'b1;
                    n_kind  = (r_mode == rle_pkg::MODE_REPEAT) ? rle_pkg::KIND_REP
                                                               : rle_pkg::KIND_LIT;
                end
            end
            rle_pkg::ST_LIT_ADD: begin
                ram_we = 1'b1;
                n_lc   = alu_res[rle_pkg::LC_W-1:0];
                n_mode = rle_pkg::MODE_LITERAL;
                if (lit_full) n_kind = rle_pkg::KIND_LIT;
            end
            rle_pkg::ST_LEN: begin
                n_body = alu_res;
                n_idx  = '0;
            end
            rle_pkg::ST_LEN2: n_body = alu_res;
            rle_pkg::ST_SIZE: n_size = alu_res;
            rle_pkg::ST_PAD:  n_pad  = alu_res & rle_pkg::PAD_MASK;
            rle_pkg::ST_EMIT_LO: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = cnt_word[rle_pkg::BYTE_W-1:0];
                    n_out_final = 1'b0;
                    n_out_size  = '0;
                    n_out_pad   = '0;
                end
            end
            rle_pkg::ST_EMIT_HI: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = cnt_word[rle_pkg::CNT_W-1:rle_pkg::BYTE_W];
                    n_out_final = 1'b0;
                    n_out_size  = '0;
                    n_out_pad   = '0;
                end
            end
            rle_pkg::ST_EMIT_DATA: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = (r_kind == rle_pkg::KIND_REP) ? r_held : ram_rdata;
                    n_out_final = data_last && r_final;
                    n_out_size  = (data_last && r_final) ? r_size : '0;
                    n_out_pad   = (data_last && r_final) ? r_pad : '0;
                    if (!data_last) begin
                        n_idx = alu_res[rle_pkg::ADDR_W-1:0];
                    end else begin
                        if (r_kind == rle_pkg::KIND_REP) begin
                            n_rc = '0;
                        end else begin
                            n_lc = '0;
                            if (r_mode == rle_pkg::MODE_LITERAL) n_mode = rle_pkg::MODE_IDLE;
                        end
                        if (r_final) begin
                            // block done: back to the state after reset
                            n_held       = '0;
                            n_held_valid = 1'b0;
                            n_mode       = rle_pkg::MODE_IDLE;
                            n_rc         = '0;
                            n_lc         = '0;
                            n_body       = '0;
                            n_final      = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rle_pkg::ST_IDLE;
            r_mode       <= rle_pkg::MODE_IDLE;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_rc         <= '0;
            r_lc         <= '0;
            r_body       <= '0;
            r_final      <= 1'b0;
            r_rc_inc     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_rc         <= n_rc;
            r_lc         <= n_lc;
            r_body       <= n_body;
            r_final      <= n_final;
            r_rc_inc     <= n_rc_inc;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_x         <= n_x;
        r_end       <= n_end;
        r_kind      <= n_kind;
        r_size      <= n_size;
        r_pad       <= n_pad;
        r_idx       <= n_idx;
        r_out_byte  <= n_out_byte;
        r_out_final <= n_out_final;
        r_out_size  <= n_out_size;
        r_out_pad   <= n_out_pad;
    end

    // an accepted byte is always judged in the following cycle
    a_accept_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == rle_pkg::ST_DECIDE)
        else $error("accepted byte not followed by decide");

    // literal store never overfills
    a_lc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lc <= rle_pkg::LC_W'(rle_pkg::RAW_MAX))
        else $error("literal count beyond limit");

    // an open repeat run always holds at least two bytes behind a valid lookahead
    a_repeat_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == rle_pkg::MODE_REPEAT |-> r_held_valid && r_rc >= rle_pkg::REP_START)
        else $error("repeat mode with short or empty run");

    // padded length follows from the size word on the final byte
    a_final_sizes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_final |->
            r_out_pad == ((r_out_size + rle_pkg::LEN_W'(7)) & rle_pkg::PAD_MASK))
        else $error("padded length inconsistent with size word");

    // size fields stay zero off the final byte
    a_nonfinal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_final |-> r_out_size == '0 && r_out_pad == '0)
        else $error("size fields set on a non-final byte");

endmodule
